// ===== rtl/pol_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pol_pkg: shared types and constants for the positional ordered list
// Field widths, action and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int ACT_W = 2;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int ST_W  = 2;
  localparam int LEN_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_DUMP   = 2'd2
  } action_t;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_DUMP_FIRST,
    OP_DUMP_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } pol_cmd_t;

  typedef struct packed {
    logic dump_short;
    logic dump_last;
  } pol_sts_t;

endpackage
`default_nettype wire

// ===== rtl/pol_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pol_req_if / pol_rsp_if: request and result channels
// Valid/ready channels carrying one operation or one result per beat.
// ----------------------------------------------------------------------------
interface pol_req_if;
  import pol_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, action, value, position, input ready);
  modport sink (input valid, action, value, position, output ready);
endinterface

interface pol_rsp_if;
  import pol_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] item_value;
  logic [ST_W-1:0]         status;
  logic                    last;
  logic [LEN_W-1:0]        length;

  modport source (output valid, item_value, status, last, length, input ready);
  modport sink (input valid, item_value, status, last, length, output ready);
endinterface
`default_nettype wire

// ===== rtl/pol_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pol_dp: list datapath
// Chain of entry cells that shifts on insert/remove and rotates during a dump,
// the entry count, the dump counter and the result register.
// ----------------------------------------------------------------------------
module pol_dp #(
  parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pol_pkg::pol_cmd_t               cmd,
  output pol_pkg::pol_sts_t               sts,
  input  logic signed [pol_pkg::VAL_W-1:0] value,
  input  logic [pol_pkg::POS_W-1:0]       position,
  output logic signed [pol_pkg::VAL_W-1:0] item_value,
  output logic [pol_pkg::ST_W-1:0]        status,
  output logic                            last,
  output logic [pol_pkg::LEN_W-1:0]       length
);
  import pol_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [VAL_W-1:0] cells      [CAPACITY];
  logic [VAL_W-1:0] cells_next [CAPACITY];
  logic [VAL_W-1:0] dn         [CAPACITY];
  logic [VAL_W-1:0] up         [CAPACITY];

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] dcnt, dcnt_next;

  logic [PW-1:0] pos_x, cnt_x, ins_slot, rem_slot;
  logic          is_full, is_empty, badpos;
  logic [VAL_W-1:0] removed;

  logic             out_load;
  logic [VAL_W-1:0] val_next;
  logic [ST_W-1:0]  st_next;
  logic             last_next;

  // neighbor taps of each cell; the tail wraps to the head for rotation
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g == 0) begin : g_head
      assign dn[g] = value;
    end else begin : g_body
      assign dn[g] = cells[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign up[g] = cells[0];
    end else begin : g_mid
      assign up[g] = cells[g+1];
    end
  end

  always_comb begin
    pos_x    = PW'(position);
    cnt_x    = PW'(count);
    is_full  = (count == CW'(CAPACITY));
    is_empty = (count == '0);
    badpos   = (pos_x > cnt_x);
    ins_slot = (pos_x == '0 || badpos) ? cnt_x : pos_x - PW'(1);
    rem_slot = (pos_x == '0) ? cnt_x - PW'(1) : pos_x - PW'(1);
    sts.dump_short = (count < CW'(2));
    sts.dump_last  = (dcnt == CW'(1));
  end

  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (PW'(i) == rem_slot) begin
        removed = removed | cells[i];
      end
    end
  end

  always_comb begin
    count_next = count;
    dcnt_next  = dcnt;
    out_load   = 1'b1;
    val_next   = '0;
    st_next    = ST_OK;
    last_next  = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      cells_next[i] = cells[i];
    end
    case (cmd.op)
      OP_INSERT: begin
        if (is_full) begin
          st_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (PW'(i) > ins_slot) begin
              cells_next[i] = dn[i];
            end else if (PW'(i) == ins_slot) begin
              cells_next[i] = value;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (is_empty) begin
          st_next = ST_EMPTY;
        end else if (badpos) begin
          st_next = ST_BADPOS;
        end else begin
          count_next = count - CW'(1);
          val_next   = removed;
          for (int i = 0; i < CAPACITY; i++) begin
            if (PW'(i) >= rem_slot) begin
              cells_next[i] = up[i];
            end
          end
        end
      end
      OP_DUMP_FIRST, OP_DUMP_NEXT: begin
        if (cmd.op == OP_DUMP_FIRST && is_empty) begin
          st_next = ST_EMPTY;
        end else begin
          val_next = cells[0];
          if (cmd.op == OP_DUMP_FIRST) begin
            last_next = (count == CW'(1));
            dcnt_next = count - CW'(1);
          end else begin
            last_next = (dcnt == CW'(1));
            dcnt_next = dcnt - CW'(1);
          end
          // rotate the occupied part so the head walks out one beat at a time
          for (int i = 0; i < CAPACITY; i++) begin
            if (PW'(i) + PW'(1) < cnt_x) begin
              cells_next[i] = up[i];
            end else if (PW'(i) + PW'(1) == cnt_x) begin
              cells_next[i] = cells[0];
            end
          end
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      dcnt  <= '0;
    end else begin
      count <= count_next;
      dcnt  <= dcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells[i] <= cells_next[i];
    end
    if (out_load) begin
      item_value <= val_next;
      status     <= st_next;
      last       <= last_next;
      length     <= LEN_W'(count_next);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pol_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pol_ctrl: list controller
// Accepts operations, sequences dump beats and owns the result valid flag.
// ----------------------------------------------------------------------------
module pol_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [pol_pkg::ACT_W-1:0] req_action,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  input  pol_pkg::pol_sts_t         sts,
  output pol_pkg::pol_cmd_t         cmd
);
  import pol_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   out_free;
  logic   accept;

  always_comb begin
    out_free       = !rsp_valid || rsp_ready;
    req_ready      = (state == S_IDLE) && out_free;
    accept         = req_valid && req_ready;
    cmd.op         = OP_NONE;
    state_next     = state;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action_t'(req_action))
            ACT_INSERT: begin
              cmd.op         = OP_INSERT;
              rsp_valid_next = 1'b1;
            end
            ACT_REMOVE: begin
              cmd.op         = OP_REMOVE;
              rsp_valid_next = 1'b1;
            end
            ACT_DUMP: begin
              cmd.op         = OP_DUMP_FIRST;
              rsp_valid_next = 1'b1;
              if (!sts.dump_short) begin
                state_next = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd.op         = OP_DUMP_NEXT;
          rsp_valid_next = 1'b1;
          if (sts.dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/positional_ordered_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded ordered list with positional insert/remove
//
//   channel  dir  beat contents
//   req      in   action, value, position
//   rsp      out  item_value, status, last, length
//
// On insert and remove the cell chain shifts every later entry at once and the
// result lands in the output register. A dump gives one beat per cycle while
// rsp is not stalled (one beat for an empty list) by emitting the head cell and
// rotating the occupied cells by one.
// req is taken only when the result register is empty or drains that cycle and
// never during a dump; a stalled rsp holds its beat and req waits. Reset empties
// the list; entry contents are not cleared.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
  parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst,
  pol_req_if.sink  req,
  pol_rsp_if.source rsp
);
  import pol_pkg::*;

  pol_cmd_t cmd;
  pol_sts_t sts;

  pol_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_action (req.action),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pol_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value      (req.value),
    .position   (req.position),
    .item_value (rsp.item_value),
    .status     (rsp.status),
    .last       (rsp.last),
    .length     (rsp.length)
  );

  // no new request while dump beats are still being produced
  a_dump_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DUMP_NEXT) |-> !req.ready)
    else $error("request taken during dump");

  // insert and remove always produce a beat in the next cycle
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready &&
     (req.action == ACT_INSERT || req.action == ACT_REMOVE)) |=> rsp.valid)
    else $error("missing result for insert or remove");

  // only dump beats are non-final, and those are always ok
  a_nonlast_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.last) |-> (rsp.status == ST_OK))
    else $error("non-final beat with error status");

endmodule
`default_nettype wire
